>>> rtl/seat_credential_slot_table_core_macros.svh
// ----------------------------------------------------------------------------
// Seat credential slot table assertion macros
// Shared concurrent assertion forms, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SEAT_CREDENTIAL_SLOT_TABLE_CORE_MACROS_SVH
`define SEAT_CREDENTIAL_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SCST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/scst_pkg.sv
// ----------------------------------------------------------------------------
// Seat credential slot table package
// Command codes, slot record and the control/result groups of the table.
// ----------------------------------------------------------------------------
package scst_pkg;

  localparam int KIND_W = 4;
  localparam int SEAT_W = 3;
  localparam int GEN_W  = 32;
  localparam int CRED_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN       = 4'd0,
    KIND_END         = 4'd1,
    KIND_ISSUE       = 4'd2,
    KIND_ADOPT       = 4'd3,
    KIND_MATCH       = 4'd4,
    KIND_ACTIVE_GEN  = 4'd5,
    KIND_PEEK_NEXT   = 4'd6,
    KIND_RETIRE      = 4'd7,
    KIND_HAS_RETIRED = 4'd8,
    KIND_CLR_RETIRED = 4'd9,
    KIND_REVOKE      = 4'd10
  } kind_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic             act;
    logic [GEN_W-1:0] rgen;
    logic             rvalid;
  } slot_ctl_t;

  typedef struct packed {
    logic slot_we;
    logic clear_all;
    logic open_nxt;
  } upd_t;

  typedef struct packed {
    logic             ok;
    logic [GEN_W-1:0] gen;
  } result_t;

endpackage

>>> rtl/scst_slot_eval.sv
// ----------------------------------------------------------------------------
// Seat credential slot table command evaluation
// Decodes one command against the addressed slot; produces the result,
// the slot's next contents and the table update controls.
// ----------------------------------------------------------------------------
module scst_slot_eval #(
  parameter int SECRET_BITS = 64
) (
  input  logic [scst_pkg::KIND_W-1:0] kind,
  input  logic                        seat_ok,
  input  logic [scst_pkg::GEN_W-1:0]  hgen,
  input  logic [SECRET_BITS-1:0]      cred,
  input  logic                        session_open,
  input  scst_pkg::slot_ctl_t         slot_cur,
  input  logic [SECRET_BITS-1:0]      sec_cur,
  output scst_pkg::slot_ctl_t         slot_nxt,
  output logic [SECRET_BITS-1:0]      sec_nxt,
  output scst_pkg::upd_t              upd,
  output scst_pkg::result_t           res
);

  logic [scst_pkg::GEN_W-1:0] gen_inc;
  logic [scst_pkg::GEN_W-1:0] next_gen;
  logic                       hgen_nz;

  assign gen_inc  = slot_cur.gen + scst_pkg::GEN_W'(1);
  assign next_gen = session_open ? gen_inc : '0;
  assign hgen_nz  = (hgen != '0);

  always_comb begin
    slot_nxt = slot_cur;
    sec_nxt  = sec_cur;
    upd      = '0;
    res      = '0;
    unique case (scst_pkg::kind_t'(kind))
      scst_pkg::KIND_BEGIN: begin
        upd.clear_all = 1'b1;
        upd.open_nxt  = 1'b1;
        res.ok        = 1'b1;
      end
      scst_pkg::KIND_END: begin
        upd.clear_all = 1'b1;
        res.ok        = 1'b1;
      end
      scst_pkg::KIND_ISSUE: begin
        if (seat_ok && session_open) begin
          slot_nxt.gen = gen_inc;
          slot_nxt.act = 1'b1;
          sec_nxt      = cred;
          upd.slot_we  = 1'b1;
          res.ok       = 1'b1;
          res.gen      = gen_inc;
        end
      end
      scst_pkg::KIND_ADOPT: begin
        if (seat_ok && session_open && hgen_nz && (hgen == next_gen)) begin
          slot_nxt.gen = hgen;
          slot_nxt.act = 1'b1;
          sec_nxt      = cred;
          upd.slot_we  = 1'b1;
          res.ok       = 1'b1;
        end
      end
      scst_pkg::KIND_MATCH: begin
        res.ok = seat_ok && session_open && hgen_nz && slot_cur.act &&
                 (slot_cur.gen == hgen) && (sec_cur == cred);
      end
      scst_pkg::KIND_ACTIVE_GEN: begin
        if (seat_ok && session_open && slot_cur.act) begin
          res.ok  = 1'b1;
          res.gen = slot_cur.gen;
        end
      end
      scst_pkg::KIND_PEEK_NEXT: begin
        if (seat_ok) begin
          res.gen = next_gen;
          res.ok  = (next_gen != '0);
        end
      end
      scst_pkg::KIND_RETIRE: begin
        if (seat_ok && slot_cur.act) begin
          slot_nxt.rgen   = slot_cur.gen;
          slot_nxt.rvalid = 1'b1;
          upd.slot_we     = 1'b1;
          res.ok          = 1'b1;
        end
      end
      scst_pkg::KIND_HAS_RETIRED: begin
        res.ok = seat_ok && session_open && hgen_nz && slot_cur.rvalid &&
                 (slot_cur.rgen == hgen);
      end
      scst_pkg::KIND_CLR_RETIRED: begin
        if (seat_ok) begin
          slot_nxt.rgen   = '0;
          slot_nxt.rvalid = 1'b0;
          upd.slot_we     = 1'b1;
          res.ok          = 1'b1;
        end
      end
      scst_pkg::KIND_REVOKE: begin
        if (seat_ok) begin
          slot_nxt.act    = 1'b0;
          slot_nxt.rgen   = '0;
          slot_nxt.rvalid = 1'b0;
          sec_nxt         = '0;
          upd.slot_we     = 1'b1;
          res.ok          = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> rtl/seat_credential_slot_table_core.sv
// ----------------------------------------------------------------------------
// Seat credential slot table core
// Per-seat generation/credential slots with session, issue, adopt, match,
// retire and revoke commands; one result beat per command.
// ----------------------------------------------------------------------------
// A command is taken on any cycle with start high; busy is held low, so one
// command per cycle is sustained. Each command returns exactly one result
// beat, out_valid high for one cycle: the command is held in the command
// register, then passes through the slot evaluation into the result
// register. The receiver cannot stall, so results must be taken as
// they appear. The slot table is held in flip-flops and updated in the same
// cycle the result is registered, so back-to-back commands on one seat see
// each other's effects in order.
module seat_credential_slot_table_core #(
  parameter int SEAT_COUNT  = 8,
  parameter int SECRET_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [scst_pkg::KIND_W-1:0] in_kind,
  input  logic [scst_pkg::SEAT_W-1:0] in_seat,
  input  logic [scst_pkg::GEN_W-1:0]  in_generation,
  input  logic [scst_pkg::CRED_W-1:0] in_credential,
  output logic                        out_valid,
  output logic                        out_ok,
  output logic [scst_pkg::GEN_W-1:0]  out_gen_out
);

  `include "seat_credential_slot_table_core_macros.svh"

  localparam int IDX_W = (SEAT_COUNT > 1) ? $clog2(SEAT_COUNT) : 1;

  logic                        in_vld_r;
  logic [scst_pkg::KIND_W-1:0] kind_r;
  logic [scst_pkg::SEAT_W-1:0] seat_r;
  logic [scst_pkg::GEN_W-1:0]  hgen_r;
  logic [SECRET_BITS-1:0]      cred_r;

  logic                        session_open_r;
  scst_pkg::slot_ctl_t         slot_r [SEAT_COUNT];
  logic [SECRET_BITS-1:0]      sec_r  [SEAT_COUNT];
  logic [SEAT_COUNT-1:0]       act_vec;

  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [scst_pkg::GEN_W-1:0]  out_gen_r;

  logic [31:0]                 seat_ext;
  logic [IDX_W-1:0]            idx;
  logic                        seat_ok;
  scst_pkg::slot_ctl_t         slot_cur;
  logic [SECRET_BITS-1:0]      sec_cur;
  scst_pkg::slot_ctl_t         slot_nxt;
  logic [SECRET_BITS-1:0]      sec_nxt;
  scst_pkg::upd_t              upd;
  scst_pkg::result_t           res;

  assign busy = 1'b0;

  assign seat_ext = 32'(seat_r);
  assign idx      = seat_ext[IDX_W-1:0];
  assign seat_ok  = (seat_ext < 32'(SEAT_COUNT));
  assign slot_cur = seat_ok ? slot_r[idx] : '0;
  assign sec_cur  = seat_ok ? sec_r[idx] : '0;

  always_comb begin
    for (int i = 0; i < SEAT_COUNT; i++) begin
      act_vec[i] = slot_r[i].act;
    end
  end

  scst_slot_eval #(
    .SECRET_BITS (SECRET_BITS)
  ) u_eval (
    .kind         (kind_r),
    .seat_ok      (seat_ok),
    .hgen         (hgen_r),
    .cred         (cred_r),
    .session_open (session_open_r),
    .slot_cur     (slot_cur),
    .sec_cur      (sec_cur),
    .slot_nxt     (slot_nxt),
    .sec_nxt      (sec_nxt),
    .upd          (upd),
    .res          (res)
  );

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= in_kind;
      seat_r <= in_seat;
      hgen_r <= in_generation;
      cred_r <= in_credential[SECRET_BITS-1:0];
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_open_r <= 1'b0;
      for (int i = 0; i < SEAT_COUNT; i++) begin
        slot_r[i] <= '0;
        sec_r[i]  <= '0;
      end
    end else if (in_vld_r) begin
      if (upd.clear_all) begin
        session_open_r <= upd.open_nxt;
        for (int i = 0; i < SEAT_COUNT; i++) begin
          slot_r[i] <= '0;
          sec_r[i]  <= '0;
        end
      end else if (upd.slot_we) begin
        slot_r[idx] <= slot_nxt;
        sec_r[idx]  <= sec_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_ok_r  <= res.ok;
      out_gen_r <= res.gen;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_gen_out = out_gen_r;

  `SCST_ASSERT_NEXT(a_beat_follows, in_vld_r, out_valid_r, "command produced no result beat")
  `SCST_ASSERT_IMPL(a_fail_no_gen, out_valid_r && !out_ok_r, out_gen_r == '0, "failed result carries a generation")
  `SCST_ASSERT_NEXT(a_begin_opens, in_vld_r && (kind_r == scst_pkg::KIND_BEGIN), session_open_r && (act_vec == '0), "begin did not open a clean session")
  `SCST_ASSERT_IMPL(a_closed_idle, !session_open_r, act_vec == '0, "active slot while session closed")

endmodule

>>> bench/scst_slot_table_checker.sv
// ----------------------------------------------------------------------------
// Seat credential slot table result checker
// Watches the command and result channels of the slot table core. Keeps its
// own copy of the session flag and the per-seat slots, works out the answer
// to each accepted command and compares every result beat, field by field,
// against the oldest answer still due.
// ----------------------------------------------------------------------------
module scst_slot_table_checker #(
  parameter int SEAT_COUNT  = 8,
  parameter int SECRET_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [scst_pkg::KIND_W-1:0] in_kind,
  input  logic [scst_pkg::SEAT_W-1:0] in_seat,
  input  logic [scst_pkg::GEN_W-1:0]  in_generation,
  input  logic [scst_pkg::CRED_W-1:0] in_credential,
  input  logic                        out_valid,
  input  logic                        out_ok,
  input  logic [scst_pkg::GEN_W-1:0]  out_gen_out,
  output int                          fail_count,
  output int                          answers_pending
);
  import scst_pkg::*;

  localparam logic [CRED_W-1:0] CRED_MASK = {CRED_W{1'b1}} >> (CRED_W - SECRET_BITS);
  localparam int MAX_LINES = 40;

  logic              session_open;
  logic [GEN_W-1:0]  slot_gen    [SEAT_COUNT];
  logic              slot_act    [SEAT_COUNT];
  logic [CRED_W-1:0] slot_secret [SEAT_COUNT];
  logic [GEN_W-1:0]  slot_rgen   [SEAT_COUNT];
  logic              slot_rvalid [SEAT_COUNT];

  result_t answers_due[$];

  initial begin
    fail_count      = 0;
    answers_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < MAX_LINES) begin
      $display("%0t: result %s got %0h expected %0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic void wipe_slots();
    slot_gen    = '{default: '0};
    slot_act    = '{default: 1'b0};
    slot_secret = '{default: '0};
    slot_rgen   = '{default: '0};
    slot_rvalid = '{default: 1'b0};
  endfunction

  function automatic result_t slot_table_answer(input logic [KIND_W-1:0] k,
                                                input logic [SEAT_W-1:0] seat,
                                                input logic [GEN_W-1:0]  hgen,
                                                input logic [CRED_W-1:0] cred_in);
    result_t           r;
    logic [CRED_W-1:0] cred;
    logic [GEN_W-1:0]  nxt;
    r    = '0;
    cred = cred_in & CRED_MASK;
    if (k == KIND_BEGIN || k == KIND_END) begin
      wipe_slots();
      session_open = (k == KIND_BEGIN);
      r.ok = 1'b1;
      return r;
    end
    if (k > KIND_REVOKE || int'(seat) >= SEAT_COUNT) begin
      return r;
    end
    nxt = session_open ? slot_gen[seat] + 1'b1 : '0;
    case (kind_t'(k))
      KIND_ISSUE: begin
        if (session_open) begin
          slot_gen[seat]    = slot_gen[seat] + 1'b1;
          slot_act[seat]    = 1'b1;
          slot_secret[seat] = cred;
          r.ok  = 1'b1;
          r.gen = slot_gen[seat];
        end
      end
      KIND_ADOPT: begin
        if (session_open && hgen != '0 && hgen == nxt) begin
          slot_gen[seat]    = hgen;
          slot_act[seat]    = 1'b1;
          slot_secret[seat] = cred;
          r.ok = 1'b1;
        end
      end
      KIND_MATCH: begin
        r.ok = session_open && hgen != '0 && slot_act[seat] &&
               slot_gen[seat] == hgen && slot_secret[seat] == cred;
      end
      KIND_ACTIVE_GEN: begin
        if (session_open && slot_act[seat]) begin
          r.ok  = 1'b1;
          r.gen = slot_gen[seat];
        end
      end
      KIND_PEEK_NEXT: begin
        r.gen = nxt;
        r.ok  = nxt != '0;
      end
      KIND_RETIRE: begin
        if (slot_act[seat]) begin
          slot_rgen[seat]   = slot_gen[seat];
          slot_rvalid[seat] = 1'b1;
          r.ok = 1'b1;
        end
      end
      KIND_HAS_RETIRED: begin
        r.ok = session_open && hgen != '0 && slot_rvalid[seat] && slot_rgen[seat] == hgen;
      end
      KIND_CLR_RETIRED: begin
        slot_rvalid[seat] = 1'b0;
        slot_rgen[seat]   = '0;
        r.ok = 1'b1;
      end
      default: begin
        slot_act[seat]    = 1'b0;
        slot_secret[seat] = '0;
        slot_rvalid[seat] = 1'b0;
        slot_rgen[seat]   = '0;
        r.ok = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t due;
    if (!rst_n) begin
      session_open = 1'b0;
      wipe_slots();
      answers_due.delete();
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report_mismatch("beat with nothing due, ok", 64'(out_ok), 64'h0);
        end else begin
          want = answers_due.pop_front();
          if (out_ok !== want.ok) begin
            report_mismatch("ok", 64'(out_ok), 64'(want.ok));
          end
          if (out_gen_out !== want.gen) begin
            report_mismatch("gen_out", 64'(out_gen_out), 64'(want.gen));
          end
        end
      end
      if (start && !busy) begin
        due = slot_table_answer(in_kind, in_seat, in_generation, in_credential);
        answers_due = {answers_due, due};
      end
    end
    answers_pending <= answers_due.size();
  end

endmodule

>>> bench/tb_seat_credential_slot_table_core.sv
// ----------------------------------------------------------------------------
// Seat credential slot table core testbench
// Drives a directed command sequence through the session, slot and retired
// paths, then bursts of random commands biased toward small generations and
// a small credential pool so that adopt, match and retired queries hit.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_seat_credential_slot_table_core;
  import scst_pkg::*;

  localparam int N_RANDOM   = 800;
  localparam int QUIET_MAX  = 500;
  localparam int TAIL_CYCLES = 6;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [KIND_W-1:0] in_kind;
  logic [SEAT_W-1:0] in_seat;
  logic [GEN_W-1:0]  in_generation;
  logic [CRED_W-1:0] in_credential;
  logic              out_valid;
  logic              out_ok;
  logic [GEN_W-1:0]  out_gen_out;
  int                fail_count;
  int                answers_pending;
  int                quiet_cycles;

  logic [CRED_W-1:0] cred_pool [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                       64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001};

  seat_credential_slot_table_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_seat       (in_seat),
    .in_generation (in_generation),
    .in_credential (in_credential),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_gen_out   (out_gen_out)
  );

  scst_slot_table_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_seat         (in_seat),
    .in_generation   (in_generation),
    .in_credential   (in_credential),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_gen_out     (out_gen_out),
    .fail_count      (fail_count),
    .answers_pending (answers_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_MAX) begin
      $display("seat_credential_slot_table_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the beat until accepted; start stays high for a following beat
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [SEAT_W-1:0] s,
                          input logic [GEN_W-1:0] g, input logic [CRED_W-1:0] c);
    @(negedge clk);
    start         <= 1'b1;
    in_kind       <= k;
    in_seat       <= s;
    in_generation <= g;
    in_credential <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  initial begin
    int                burst_left;
    int                pick;
    logic [KIND_W-1:0] k;
    logic [SEAT_W-1:0] s;
    logic [GEN_W-1:0]  g;
    logic [CRED_W-1:0] c;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = '0;
    in_seat       = '0;
    in_generation = '0;
    in_credential = '0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // session closed
    send_cmd(KIND_ISSUE, 3'd0, 32'd0, 64'hDEAD_BEEF_0000_0001);
    send_cmd(KIND_PEEK_NEXT, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_REVOKE, 3'd1, 32'd0, 64'h0);
    send_cmd(KIND_BEGIN, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(KIND_ISSUE, 3'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(KIND_ACTIVE_GEN, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_PEEK_NEXT, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_MATCH, 3'd0, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(KIND_MATCH, 3'd0, 32'd1, 64'h0);
    send_cmd(KIND_MATCH, 3'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    idle_cycles(3);
    send_cmd(KIND_ADOPT, 3'd7, 32'd1, 64'hA5A5_A5A5_5A5A_5A5A);
    send_cmd(KIND_ADOPT, 3'd7, 32'd3, 64'h0);
    send_cmd(KIND_ADOPT, 3'd7, 32'd0, 64'h0);
    send_cmd(KIND_RETIRE, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_HAS_RETIRED, 3'd0, 32'd1, 64'h0);
    send_cmd(KIND_HAS_RETIRED, 3'd0, 32'hFFFF_FFFF, 64'h0);
    send_cmd(KIND_CLR_RETIRED, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_HAS_RETIRED, 3'd0, 32'd1, 64'h0);
    send_cmd(KIND_RETIRE, 3'd3, 32'd0, 64'h0);
    send_cmd(KIND_REVOKE, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_ACTIVE_GEN, 3'd0, 32'd0, 64'h0);
    send_cmd(4'd11, 3'd2, 32'd1, 64'h1);
    send_cmd(4'd15, 3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(KIND_END, 3'd0, 32'd0, 64'h0);
    send_cmd(KIND_MATCH, 3'd7, 32'd1, 64'hA5A5_A5A5_5A5A_5A5A);
    idle_cycles(2);

    send_cmd(KIND_BEGIN, 3'($urandom), $urandom, {$urandom, $urandom});
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if      (pick < 2)  k = KIND_BEGIN;
      else if (pick < 3)  k = KIND_END;
      else if (pick < 23) k = KIND_ISSUE;
      else if (pick < 33) k = KIND_ADOPT;
      else if (pick < 47) k = KIND_MATCH;
      else if (pick < 55) k = KIND_ACTIVE_GEN;
      else if (pick < 62) k = KIND_PEEK_NEXT;
      else if (pick < 72) k = KIND_RETIRE;
      else if (pick < 80) k = KIND_HAS_RETIRED;
      else if (pick < 85) k = KIND_CLR_RETIRED;
      else if (pick < 92) k = KIND_REVOKE;
      else if (pick < 96) k = 4'($urandom_range(11, 15));
      else                k = 4'($urandom);
      s = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 3)) : 3'($urandom);
      g = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 8));
      c = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : cred_pool[$urandom_range(0, 3)];
      send_cmd(k, s, g, c);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          idle_cycles($urandom_range(1, 6));
        end
        burst_left = $urandom_range(1, 40);
      end
    end

    idle_cycles(1);
    while (answers_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("seat_credential_slot_table_core: match");
    end else begin
      $display("seat_credential_slot_table_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/scst_pkg.sv
rtl/scst_slot_eval.sv
rtl/seat_credential_slot_table_core.sv
bench/scst_slot_table_checker.sv
bench/tb_seat_credential_slot_table_core.sv
